>>> hw/rtl/route_longest_prefix_lookup_macros.svh
// Assertion macros of the route lookup RTL.
`ifndef ROUTE_LONGEST_PREFIX_LOOKUP_MACROS_SVH
`define ROUTE_LONGEST_PREFIX_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("route lookup assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("route lookup assertion failed");

`endif

>>> hw/rtl/rlpm_pkg.sv
// Shared types and constants of the route lookup block.
package rlpm_pkg;

    localparam int ENTRIES_DEF = 1024;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;
    localparam int IDX_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int LEN_W       = 6;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    // One table entry as kept in memory; the prefix length is worked out at write.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } t_route;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] out_port;
        logic [LEN_W-1:0]  prefix_length;
    } t_result;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

>>> hw/rtl/rlpm_ifs.sv
// Handshake channels of the route lookup block: request, response, configuration.
interface rlpm_req_if import rlpm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] route_prefix;
    logic [ADDR_W-1:0] route_mask;
    logic [ADDR_W-1:0] route_next_hop;
    logic [PORT_W-1:0] route_port;
    logic [ADDR_W-1:0] dest_addr;

    modport source (
        output valid, operation, entry_index, route_prefix, route_mask,
               route_next_hop, route_port, dest_addr,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, route_prefix, route_mask,
               route_next_hop, route_port, dest_addr,
        output ready
    );
endinterface

interface rlpm_rsp_if import rlpm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] out_port;
    logic [LEN_W-1:0]  prefix_length;

    modport source (output valid, hit, gateway, out_port, prefix_length, input ready);
    modport sink   (input valid, hit, gateway, out_port, prefix_length, output ready);
endinterface

interface rlpm_cfg_if import rlpm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/rlpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlpm_ram import rlpm_pkg::*; #(
    parameter int WIDTH = $bits(t_route),
    parameter int DEPTH = ENTRIES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rlpm_engine.sv
// Request handling, table scan and best-match tracking of the route lookup.
`include "route_longest_prefix_lookup_macros.svh"

module rlpm_engine import rlpm_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int LW     = $clog2(ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COUNT_W-1:0] i_entry_count,
    rlpm_req_if.sink           i_req,
    rlpm_rsp_if.source         o_rsp,
    output t_ram_ctl           o_ram_ctl,
    output logic [AW-1:0]      o_ram_waddr,
    output t_route             o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  t_route             i_ram_rdata
);

    function automatic logic [LEN_W-1:0] ones32(input logic [ADDR_W-1:0] v);
        logic [2:0]       nib [8];
        logic [LEN_W-1:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        for (int i = 0; i < 8; i++) begin
            s = s + LEN_W'(nib[i]);
        end
        return s;
    endfunction

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_dest;
    logic [LW-1:0]     r_limit;
    logic [AW-1:0]     r_idx;
    logic              r_cmp_v;
    logic              r_found;
    logic [LEN_W-1:0]  r_best_len;
    logic [ADDR_W-1:0] r_best_hop;
    logic [PORT_W-1:0] r_best_port;
    t_result           r_out;
    logic              r_out_valid;

    logic          acc;
    logic          acc_lookup;
    logic          out_load;
    logic          last_read;
    logic          better;
    logic [31:0]   widx_wide;
    logic [31:0]   cnt_wide;
    logic [31:0]   lim_wide;
    logic [LW-1:0] n_limit;
    logic          cmp_phase;
    logic          out_zero;

    assign acc        = i_req.valid && i_req.ready;
    assign acc_lookup = acc && (i_req.operation == OP_LOOKUP);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign last_read  = (LW'(r_idx) == (r_limit - LW'(1)));

    // Clamp the searched count to the table depth.
    assign cnt_wide = 32'(i_entry_count);
    assign lim_wide = (cnt_wide > 32'(ENTRIES)) ? 32'(ENTRIES) : cnt_wide;
    assign n_limit  = lim_wide[LW-1:0];

    // Write path: slots past the table are dropped.
    assign widx_wide             = 32'(i_req.entry_index);
    assign o_ram_ctl.we          = acc && (i_req.operation == OP_WRITE)
                                   && (widx_wide < 32'(ENTRIES));
    assign o_ram_waddr           = widx_wide[AW-1:0];
    assign o_ram_wdata.prefix    = i_req.route_prefix;
    assign o_ram_wdata.mask      = i_req.route_mask;
    assign o_ram_wdata.len       = ones32(i_req.route_mask);
    assign o_ram_wdata.gateway   = i_req.route_next_hop;
    assign o_ram_wdata.port      = i_req.route_port;

    assign o_ram_ctl.re = (r_state == S_SCAN);
    assign o_ram_raddr  = r_idx;

    // Strictly longer wins, so the lowest slot keeps a tie.
    assign better = r_cmp_v
                    && ((r_dest & i_ram_rdata.mask) == i_ram_rdata.prefix)
                    && (!r_found || (i_ram_rdata.len > r_best_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= (r_state == S_SCAN);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_lookup) begin
            r_dest      <= i_req.dest_addr;
            r_limit     <= n_limit;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_best_len  <= '0;
            r_best_hop  <= '0;
            r_best_port <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_idx <= r_idx + AW'(1);
            end
            if (better) begin
                r_found     <= 1'b1;
                r_best_len  <= i_ram_rdata.len;
                r_best_hop  <= i_ram_rdata.gateway;
                r_best_port <= i_ram_rdata.port;
            end
        end
        if (out_load) begin
            r_out.hit           <= r_found;
            r_out.gateway       <= r_best_hop;
            r_out.out_port      <= r_best_port;
            r_out.prefix_length <= r_best_len;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (acc_lookup) begin
                    n_state = (n_limit == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_read) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.gateway       = r_out.gateway;
    assign o_rsp.out_port      = r_out.out_port;
    assign o_rsp.prefix_length = r_out.prefix_length;

    assign cmp_phase = (r_state == S_SCAN) || (r_state == S_FLUSH);
    assign out_zero  = (r_out.gateway == '0) && (r_out.out_port == '0)
                       && (r_out.prefix_length == '0);

    `RLPM_ASSERT_NEXT(a_lookup_leaves_idle, i_clk, i_rst_n, acc_lookup, r_state != S_IDLE)
    `RLPM_ASSERT_NOW(a_read_in_range, i_clk, i_rst_n, o_ram_ctl.re, LW'(r_idx) < r_limit)
    `RLPM_ASSERT_NOW(a_cmp_in_scan, i_clk, i_rst_n, r_cmp_v, cmp_phase)
    `RLPM_ASSERT_NOW(a_miss_is_zero, i_clk, i_rst_n, r_out_valid && !r_out.hit, out_zero)

endmodule

>>> hw/rtl/route_longest_prefix_lookup.sv
// Top level of the IPv4 route table with longest-prefix-match lookup.
//
// Channels: i_req carries request items (write a route entry, or look up a
// destination), o_rsp carries one result item per lookup, i_cfg writes the
// entry_count register (always ready; write it only while the block is idle).
// A write item is taken in S_IDLE and stores the entry into the table RAM;
// it yields no result. Slots at or past ENTRIES are dropped.
// A lookup scans slots 0 .. N-1 with N = min(entry_count, ENTRIES), reading
// one entry per cycle through the single RAM read port. The slots are read
// in S_SCAN, the last entry read is compared in S_FLUSH, and the result is
// loaded into the output register from S_DONE once that register is free;
// an empty table goes straight to S_DONE. Requests are taken only in S_IDLE,
// which the block re-enters as the result is loaded, so no request is taken
// while a lookup is in progress.
// Reset clears the control state and entry_count; the table holds whatever
// it held, and slots must be written before a lookup reaches them.
// When the receiver stalls, the result holds in the output register and the
// block takes requests until a second result waits in S_DONE for the register.
module route_longest_prefix_lookup import rlpm_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlpm_cfg_if.sink   i_cfg,
    rlpm_req_if.sink   i_req,
    rlpm_rsp_if.source o_rsp
);

    logic [COUNT_W-1:0]     r_entry_count;
    t_ram_ctl               ram_ctl;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    t_route                 ram_wdata;
    logic [$bits(t_route)-1:0] ram_rdata;

    // Configuration: one register, taken on every valid write.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_entry_count <= i_cfg.data;
        end
    end

    // Route table: prefix, mask, prefix length, next hop and port per slot.
    rlpm_ram #(
        .WIDTH ($bits(t_route)),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_ctl.re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request decode, scan sequencer and result register.
    rlpm_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_ram_ctl     (ram_ctl),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

endmodule
